// ----- rtl/c16d_pkg.sv -----
// Shared constants, types and the CRC-16 byte update for the packet deframer.
// No dependencies; used by the parser, the top level and the checker.
package c16d_pkg;

   // CRC-16, reflected form
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // frame geometry and byte counter limits
   localparam int          INDEX_W       = 17;
   localparam logic [16:0] HDR_BYTES     = 17'd12;
   localparam logic [16:0] CRC_HDR_BYTES = 17'd10;
   localparam logic [16:0] INDEX_MAX     = 17'h1FFFF;

   // header byte offsets
   localparam logic [3:0] OFS_MAGIC_LO = 4'd0;
   localparam logic [3:0] OFS_MAGIC_HI = 4'd1;
   localparam logic [3:0] OFS_VERSION  = 4'd2;
   localparam logic [3:0] OFS_TYPE     = 4'd3;
   localparam logic [3:0] OFS_SEQ_0    = 4'd4;
   localparam logic [3:0] OFS_SEQ_1    = 4'd5;
   localparam logic [3:0] OFS_SEQ_2    = 4'd6;
   localparam logic [3:0] OFS_SEQ_3    = 4'd7;
   localparam logic [3:0] OFS_LEN_LO   = 4'd8;
   localparam logic [3:0] OFS_LEN_HI   = 4'd9;
   localparam logic [3:0] OFS_CRC_LO   = 4'd10;

   // verdict codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_MAGIC     = 3'd2;
   localparam logic [2:0] ST_VERSION   = 3'd3;
   localparam logic [2:0] ST_TOO_LONG  = 3'd4;
   localparam logic [2:0] ST_TRUNCATED = 3'd5;
   localparam logic [2:0] ST_CRC       = 3'd6;

   // control register indexes and reset values
   localparam int          CSR_INDEX_W   = 2;
   localparam int          CSR_DATA_W    = 16;
   localparam logic [1:0]  CSR_MAGIC     = 2'd0;
   localparam logic [1:0]  CSR_VERSION   = 2'd1;
   localparam logic [1:0]  CSR_MAX_LEN   = 2'd2;
   localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

   // rsp_tdata width: 67 payload bits rounded up to whole bytes
   localparam int RSP_DATA_W = 72;

   typedef struct packed {
      logic [15:0] magic;
      logic [7:0]  version;
      logic [15:0] max_len;
   } cfg_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        verdict_valid;
      logic [2:0]  status;
      logic [7:0]  packet_type;
      logic [31:0] sequence_res;
      logic [15:0] payload_length;
   } result_type;

   // one byte through the reflected CRC, one bit per step
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/crc16_packet_deframer_top.sv -----
// A result beat is registered in the output register, or in the skid entry while rsp stalls.
// Throughput: one byte per cycle while req_tready is high; the frame state and the CRC byte update never hold the flow.
// Bytes that cause no result (header, trailing) are taken at the same rate.
// Output register plus one skid entry: rsp may stall one beat, then req_tready drops.
// Reset is synchronous: frame state and output valid flags are cleared, control registers take their reset values.
module crc16_packet_deframer_top (
   input  logic                              clock,
   input  logic                              reset,
   // received bytes
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // rx_byte
   input  logic                              req_tlast,  // end_of_buffer
   // results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // payload_byte[7:0], status[10:8], packet_type[18:11], sequence_res[50:19],
   // payload_length[66:51], zero fill[71:67]
   output logic [c16d_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,  // payload_valid
   output logic                              rsp_tlast,  // verdict_valid
   // control register writes
   input  logic                              csr_we,
   input  logic [c16d_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [c16d_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   c16d_pkg::cfg_type    cfg_ff;
   c16d_pkg::result_type result;
   c16d_pkg::result_type out_ff, skid_ff;
   logic                 out_valid_ff, skid_valid_ff;
   logic                 has_result;
   logic                 accept;
   logic                 pop;
   logic                 push;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign push       = accept && has_result;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic   <= '0;
         cfg_ff.version <= '0;
         cfg_ff.max_len <= c16d_pkg::MAX_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            c16d_pkg::CSR_MAGIC:   cfg_ff.magic   <= csr_wdata;
            c16d_pkg::CSR_VERSION: cfg_ff.version <= csr_wdata[7:0];
            c16d_pkg::CSR_MAX_LEN: cfg_ff.max_len <= csr_wdata;
            default: ;
         endcase
      end
   end

   c16d_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_tdata),
      .end_of_buffer (req_tlast),
      .cfg           (cfg_ff),
      .has_result    (has_result),
      .result        (result)
   );

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.payload_valid;
   assign rsp_tlast  = out_ff.verdict_valid;
   assign rsp_tdata  = {5'b0, out_ff.payload_length, out_ff.sequence_res,
                        out_ff.packet_type, out_ff.status, out_ff.payload_byte};

endmodule

// ----- rtl/c16d_parser.sv -----
// Frame parser: header capture, running CRC, payload pass-through and verdict.
// Depends on c16d_pkg.
module c16d_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   input  logic                end_of_buffer,
   input  c16d_pkg::cfg_type   cfg,
   output logic                has_result,
   output c16d_pkg::result_type result
);

   logic [c16d_pkg::INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [15:0] run_crc_ff, run_crc_in;
   logic [15:0] magic_ff, magic_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] crc_seen_ff, crc_seen_in;
   logic        pay;
   logic [c16d_pkg::INDEX_W-1:0] need_total;
   logic [2:0]  status;

   // next frame state for the current byte
   always_comb begin
      magic_in    = magic_ff;
      version_in  = version_ff;
      type_in     = type_ff;
      seq_in      = seq_ff;
      length_in   = length_ff;
      crc_seen_in = crc_seen_ff;
      run_crc_in  = run_crc_ff;
      pay         = 1'b0;
      if (byte_index_ff < c16d_pkg::HDR_BYTES) begin
         unique case (byte_index_ff[3:0])
            c16d_pkg::OFS_MAGIC_LO: magic_in[7:0]    = rx_byte;
            c16d_pkg::OFS_MAGIC_HI: magic_in[15:8]   = rx_byte;
            c16d_pkg::OFS_VERSION:  version_in       = rx_byte;
            c16d_pkg::OFS_TYPE:     type_in          = rx_byte;
            c16d_pkg::OFS_SEQ_0:    seq_in[7:0]      = seq_ff[7:0] | rx_byte;
            c16d_pkg::OFS_SEQ_1:    seq_in[15:8]     = seq_ff[15:8] | rx_byte;
            c16d_pkg::OFS_SEQ_2:    seq_in[23:16]    = seq_ff[23:16] | rx_byte;
            c16d_pkg::OFS_SEQ_3:    seq_in[31:24]    = seq_ff[31:24] | rx_byte;
            c16d_pkg::OFS_LEN_LO:   length_in[7:0]   = rx_byte;
            c16d_pkg::OFS_LEN_HI:   length_in[15:8]  = rx_byte;
            c16d_pkg::OFS_CRC_LO:   crc_seen_in[7:0] = rx_byte;
            default:                crc_seen_in[15:8] = rx_byte;
         endcase
         if (byte_index_ff < c16d_pkg::CRC_HDR_BYTES) begin
            run_crc_in = c16d_pkg::crc16_byte(run_crc_ff, rx_byte);
         end
      end else if ((byte_index_ff - c16d_pkg::HDR_BYTES) < {1'b0, length_ff}) begin
         pay        = 1'b1;
         run_crc_in = c16d_pkg::crc16_byte(run_crc_ff, rx_byte);
      end
      // saturating byte counter
      byte_index_in = (byte_index_ff == c16d_pkg::INDEX_MAX) ?
                      byte_index_ff : byte_index_ff + 17'd1;
   end

   // verdict, first failing check wins
   always_comb begin
      need_total = {1'b0, length_in} + c16d_pkg::HDR_BYTES;
      priority if (byte_index_in < c16d_pkg::HDR_BYTES)  status = c16d_pkg::ST_SHORT;
      else if (magic_in != cfg.magic)                    status = c16d_pkg::ST_MAGIC;
      else if (version_in != cfg.version)                status = c16d_pkg::ST_VERSION;
      else if (length_in > cfg.max_len)                  status = c16d_pkg::ST_TOO_LONG;
      else if (byte_index_in < need_total)               status = c16d_pkg::ST_TRUNCATED;
      else if (run_crc_in != crc_seen_in)                status = c16d_pkg::ST_CRC;
      else                                               status = c16d_pkg::ST_OK;
   end

   // result beat; fields not carried are zero
   always_comb begin
      has_result            = pay || end_of_buffer;
      result.payload_valid  = pay;
      result.payload_byte   = pay ? rx_byte : 8'h00;
      result.verdict_valid  = end_of_buffer;
      result.status         = end_of_buffer ? status : c16d_pkg::ST_OK;
      result.packet_type    = end_of_buffer ? type_in : 8'h00;
      result.sequence_res   = end_of_buffer ? seq_in : 32'h0;
      result.payload_length = end_of_buffer ? length_in : 16'h0;
   end

   // frame state; cleared after every verdict
   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_buffer)) begin
         byte_index_ff <= '0;
         run_crc_ff    <= c16d_pkg::CRC_INIT;
         magic_ff      <= '0;
         version_ff    <= '0;
         type_ff       <= '0;
         seq_ff        <= '0;
         length_ff     <= '0;
         crc_seen_ff   <= '0;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
         run_crc_ff    <= run_crc_in;
         magic_ff      <= magic_in;
         version_ff    <= version_in;
         type_ff       <= type_in;
         seq_ff        <= seq_in;
         length_ff     <= length_in;
         crc_seen_ff   <= crc_seen_in;
      end
   end

endmodule

// ----- rtl/c16d_checker.sv -----
// Port-level checks for the packet deframer, bound to the top level.
// Depends on c16d_pkg for the result beat layout.
module c16d_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [c16d_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   // no beat is left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // a stalled beat keeps its contents
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // every beat carries a payload byte, a verdict or both
   a_has_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser || rsp_tlast)
      else $error("result beat with neither payload nor verdict");

   // header fields and status only appear with a verdict
   a_hdr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[71:8] == '0)
      else $error("header fields set on a beat without verdict");

   // payload byte only appears with payload_valid, status stays in range
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser || rsp_tdata[7:0] == 8'h00)
         && rsp_tdata[10:8] <= c16d_pkg::ST_CRC)
      else $error("stray payload byte or bad status code");

endmodule

bind crc16_packet_deframer_top c16d_checker u_c16d_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
